>>> hdl/gmg_pkg.sv
// Package for the grid mesh generator: widths, register indexes, request modes,
// the grid size clamp and the status struct of the reciprocal unit.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package gmg_pkg;

	localparam int GRID_MAX    = 256;
	localparam int DIM_W       = 9;
	localparam int COORD_W     = 8;
	localparam int DIV_W       = 8;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int RECIP_STEPS = RECIP_SHIFT + 1;
	localparam int STEP_W      = $clog2(RECIP_STEPS);
	localparam int FRAC_SHIFT  = 16;
	localparam int FRAC_W      = FRAC_SHIFT + 1;
	localparam int POS_W       = 17;
	localparam int TEX_W       = 24;
	localparam int IDX_W       = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_ADDR_W  = 3;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 184;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_COLS   = 3'd0,
		REG_ROWS   = 3'd1,
		REG_HALF_W = 3'd2,
		REG_HALF_H = 3'd3,
		REG_TILE_X = 3'd4,
		REG_TILE_Y = 3'd5
	} cfg_reg_t;

	localparam logic MODE_VERTEX = 1'b0;
	localparam logic MODE_CELL   = 1'b1;

	typedef struct packed {
		logic               busy;
		logic [RECIP_W-1:0] recip;
	} recip_stat_t;

	// Effective grid size: values below two act as two, values above the
	// grid limit act as the limit.
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v < DIM_W'(2)) begin
			r = DIM_W'(2);
		end else if (v > DIM_W'(GRID_MAX)) begin
			r = DIM_W'(GRID_MAX);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

>>> hdl/grid_mesh_generator.sv
// Top level of the grid mesh generator: configuration registers, two reciprocal
// units and the five-stage vertex and cell pipeline. Uses gmg_pkg and gmg_recip.
`timescale 1ns / 1ps

//  channel   | direction | payload
//  ----------+-----------+--------------------------------------------------------
//  s_*       | in        | tdata: row, col; tuser: mode (0 vertex, 1 cell)
//  m_*       | out       | tdata: pos_x, pos_y, tex_u, tex_v, idx_a..idx_f; tuser: range_error
//  cfg_*     | in        | write only: cols, rows, half_width, half_height, tile_x, tile_y
//
// A request accepted at a clock edge is captured in stage 1 and moves on through stages
// 2, 3 and 4 into the stage 5 output register. A new request can enter in every cycle
// while s_tready is high, that is while no reciprocal runs and the pipeline can advance.
// Reset leaves the grid at two by two with unit extents and tiling; no sweep is
// needed after reset. A write to cols or rows starts a reciprocal computation for the
// new size, and s_tready stays low while it runs.
// A stall on m_tready holds the output register; earlier stages keep filling
// bubbles, so s_tready only falls once every stage holds a request.

module grid_mesh_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [gmg_pkg::IN_DATA_W-1:0]  s_tdata,   // row [7:0], col [15:8]
	input  logic                           s_tuser,   // mode [0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [gmg_pkg::OUT_DATA_W-1:0] m_tdata,   // pos_x, pos_y, tex_u, tex_v,
	                                                  // idx_a..idx_f, zero pad
	output logic                           m_tuser,   // range_error [0]
	input  logic                           cfg_we,
	input  logic [gmg_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [gmg_pkg::CFG_W-1:0]      cfg_wdata
);
	import gmg_pkg::*;

	// Configuration registers.
	logic [DIM_W-1:0] cols_q, rows_q;
	logic [CFG_W-1:0] half_w_q, half_h_q, tile_x_q, tile_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q   <= DIM_W'(2);
			rows_q   <= DIM_W'(2);
			half_w_q <= CFG_W'(2048);
			half_h_q <= CFG_W'(2048);
			tile_x_q <= CFG_W'(256);
			tile_y_q <= CFG_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_COLS:   cols_q   <= cfg_wdata[DIM_W-1:0];
				REG_ROWS:   rows_q   <= cfg_wdata[DIM_W-1:0];
				REG_HALF_W: half_w_q <= cfg_wdata;
				REG_HALF_H: half_h_q <= cfg_wdata;
				REG_TILE_X: tile_x_q <= cfg_wdata;
				REG_TILE_Y: tile_y_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Each reciprocal unit restarts on a write of its grid size, taking the divisor,
	// the clamped size minus one, straight from the write data.
	logic [DIM_W-1:0] wr_dim;
	logic [DIV_W-1:0] wr_div;
	logic             start_u, start_v;
	recip_stat_t      stat_u, stat_v;

	assign wr_dim  = clamp_dim(cfg_wdata[DIM_W-1:0]);
	assign wr_div  = DIV_W'(wr_dim - DIM_W'(1));
	assign start_u = cfg_we && (cfg_addr == REG_COLS);
	assign start_v = cfg_we && (cfg_addr == REG_ROWS);

	gmg_recip u_recip_u (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_u),
		.d      (wr_div),
		.stat   (stat_u)
	);

	gmg_recip u_recip_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_v),
		.d      (wr_div),
		.stat   (stat_v)
	);

	// Effective grid sizes and the divisors cols-1 and rows-1.
	logic [DIM_W-1:0] nc, nr;
	logic [DIV_W-1:0] du, dv;

	assign nc = clamp_dim(cols_q);
	assign nr = clamp_dim(rows_q);
	assign du = DIV_W'(nc - DIM_W'(1));
	assign dv = DIV_W'(nr - DIM_W'(1));

	// Stage handshake: a stage loads when it is empty or its content moves on.
	logic v1_q, v2_q, v3_q, v4_q, v5_q;
	logic adv1, adv2, adv3, adv4, adv5;

	assign adv5     = !v5_q || m_tready;
	assign adv4     = !v4_q || adv5;
	assign adv3     = !v3_q || adv4;
	assign adv2     = !v2_q || adv3;
	assign adv1     = !v1_q || adv2;
	assign s_tready = adv1 && !stat_u.busy && !stat_v.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
		end else begin
			if (adv1) v1_q <= s_tvalid && s_tready;
			if (adv2) v2_q <= v1_q;
			if (adv3) v3_q <= v2_q;
			if (adv4) v4_q <= v3_q;
			if (adv5) v5_q <= v4_q;
		end
	end

	// Stage 1: range check, reciprocal products and the row base index.
	logic [COORD_W-1:0] in_r, in_c;
	logic               err_in;
	logic [DIM_W-1:0]   r_ext, c_ext;

	assign in_r  = s_tdata[COORD_W-1:0];
	assign in_c  = s_tdata[2*COORD_W-1:COORD_W];
	assign r_ext = {1'b0, in_r};
	assign c_ext = {1'b0, in_c};

	always_comb begin
		if (s_tuser == MODE_CELL) begin
			err_in = (r_ext + DIM_W'(1) >= nr) || (c_ext + DIM_W'(1) >= nc);
		end else begin
			err_in = (r_ext >= nr) || (c_ext >= nc);
		end
	end

	logic                       mode_s1, err_s1;
	logic [COORD_W-1:0]         r_s1, c_s1;
	logic [COORD_W+RECIP_W-1:0] pu_s1, pv_s1;
	logic [IDX_W:0]             ip_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			mode_s1 <= s_tuser;
			err_s1  <= err_in;
			r_s1    <= in_r;
			c_s1    <= in_c;
			pu_s1   <= (COORD_W+RECIP_W)'(in_c) * (COORD_W+RECIP_W)'(stat_u.recip);
			pv_s1   <= (COORD_W+RECIP_W)'(in_r) * (COORD_W+RECIP_W)'(stat_v.recip);
			ip_s1   <= (IDX_W+1)'(nc) * (IDX_W+1)'(in_r);
		end
	end

	// Stage 2: fraction estimate (exact or one low) and its back product;
	// corner indices of the cell.
	logic [FRAC_W-1:0] qu_est, qv_est;

	assign qu_est = pu_s1[FRAC_W+COORD_W-1:COORD_W];
	assign qv_est = pv_s1[FRAC_W+COORD_W-1:COORD_W];

	logic                      mode_s2, err_s2;
	logic [COORD_W-1:0]        r_s2, c_s2;
	logic [FRAC_W-1:0]         qu_s2, qv_s2;
	logic [FRAC_W+DIV_W-1:0]   qud_s2, qvd_s2;
	logic [IDX_W-1:0]          lo_s2, hi_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			mode_s2 <= mode_s1;
			err_s2  <= err_s1;
			r_s2    <= r_s1;
			c_s2    <= c_s1;
			qu_s2   <= qu_est;
			qv_s2   <= qv_est;
			qud_s2  <= (FRAC_W+DIV_W)'(qu_est) * (FRAC_W+DIV_W)'(du);
			qvd_s2  <= (FRAC_W+DIV_W)'(qv_est) * (FRAC_W+DIV_W)'(dv);
			lo_s2   <= IDX_W'(ip_s1 + {{(IDX_W+1-COORD_W){1'b0}}, c_s1});
			hi_s2   <= IDX_W'(ip_s1 + {{(IDX_W+1-DIM_W){1'b0}}, nc}
			                  + {{(IDX_W+1-COORD_W){1'b0}}, c_s1});
		end
	end

	// Stage 3: correct the fraction by one where the remainder reaches the divisor.
	logic [FRAC_W+DIV_W-1:0] rem_u, rem_v;

	assign rem_u = {1'b0, c_s2, {FRAC_SHIFT{1'b0}}} - qud_s2;
	assign rem_v = {1'b0, r_s2, {FRAC_SHIFT{1'b0}}} - qvd_s2;

	logic              mode_s3, err_s3;
	logic [FRAC_W-1:0] fu_s3, fv_s3;
	logic [IDX_W-1:0]  lo_s3, hi_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			mode_s3 <= mode_s2;
			err_s3  <= err_s2;
			fu_s3   <= qu_s2 + FRAC_W'(rem_u >= {{FRAC_W{1'b0}}, du});
			fv_s3   <= qv_s2 + FRAC_W'(rem_v >= {{FRAC_W{1'b0}}, dv});
			lo_s3   <= lo_s2;
			hi_s3   <= hi_s2;
		end
	end

	// Stage 4: position and texture products. 2*f - 65536 lies in -65536..65536.
	logic signed [FRAC_W+1:0] tu, tv;

	assign tu = $signed({1'b0, fu_s3, 1'b0}) - $signed((FRAC_W+2)'(1 << FRAC_SHIFT));
	assign tv = $signed({1'b0, fv_s3, 1'b0}) - $signed((FRAC_W+2)'(1 << FRAC_SHIFT));

	logic                          mode_s4, err_s4;
	logic signed [CFG_W+FRAC_W+2:0] px_s4, py_s4;
	logic [FRAC_W+CFG_W-1:0]       tu_s4, tv_s4;
	logic [IDX_W-1:0]              lo_s4, hi_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			mode_s4 <= mode_s3;
			err_s4  <= err_s3;
			px_s4   <= (CFG_W+FRAC_W+3)'($signed({1'b0, half_w_q}))
			           * (CFG_W+FRAC_W+3)'(tu);
			py_s4   <= (CFG_W+FRAC_W+3)'($signed({1'b0, half_h_q}))
			           * (CFG_W+FRAC_W+3)'(tv);
			tu_s4   <= (FRAC_W+CFG_W)'(fu_s3) * (FRAC_W+CFG_W)'(tile_x_q);
			tv_s4   <= (FRAC_W+CFG_W)'(fv_s3) * (FRAC_W+CFG_W)'(tile_y_q);
			lo_s4   <= lo_s3;
			hi_s4   <= hi_s3;
		end
	end

	// Stage 5: output register. Dropping the low 16 bits of the signed product
	// rounds toward minus infinity; fields the mode does not use are zero.
	logic              vert_ok, cell_ok;
	logic [POS_W-1:0]  pos_x_s5, pos_y_s5;
	logic [TEX_W-1:0]  tex_u_s5, tex_v_s5;
	logic [IDX_W-1:0]  idx_a_s5, idx_b_s5, idx_c_s5, idx_d_s5, idx_e_s5, idx_f_s5;
	logic              err_s5;

	assign vert_ok = !err_s4 && (mode_s4 == MODE_VERTEX);
	assign cell_ok = !err_s4 && (mode_s4 == MODE_CELL);

	always_ff @(posedge clk) begin
		if (adv5) begin
			err_s5   <= err_s4;
			pos_x_s5 <= vert_ok ? px_s4[FRAC_SHIFT+POS_W-1:FRAC_SHIFT] : '0;
			pos_y_s5 <= vert_ok ? py_s4[FRAC_SHIFT+POS_W-1:FRAC_SHIFT] : '0;
			tex_u_s5 <= vert_ok ? tu_s4[TEX_W+7:8] : '0;
			tex_v_s5 <= vert_ok ? tv_s4[TEX_W+7:8] : '0;
			idx_a_s5 <= cell_ok ? lo_s4 : '0;
			idx_b_s5 <= cell_ok ? lo_s4 + IDX_W'(1) : '0;
			idx_c_s5 <= cell_ok ? hi_s4 : '0;
			idx_d_s5 <= cell_ok ? lo_s4 + IDX_W'(1) : '0;
			idx_e_s5 <= cell_ok ? hi_s4 + IDX_W'(1) : '0;
			idx_f_s5 <= cell_ok ? hi_s4 : '0;
		end
	end

	assign m_tvalid = v5_q;
	assign m_tuser  = err_s5;
	assign m_tdata  = {6'b0, idx_f_s5, idx_e_s5, idx_d_s5, idx_c_s5, idx_b_s5, idx_a_s5,
	                   tex_v_s5, tex_u_s5, pos_y_s5, pos_x_s5};

endmodule

>>> hdl/gmg_recip.sv
// Serial reciprocal unit: floor(2^24 / d) for an 8-bit divisor, one quotient
// bit per cycle by restoring division. Uses gmg_pkg.
`timescale 1ns / 1ps

module gmg_recip (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [gmg_pkg::DIV_W-1:0] d,
	output gmg_pkg::recip_stat_t      stat
);
	import gmg_pkg::*;

	logic [DIV_W-1:0]   d_q;
	logic [DIV_W-1:0]   rem_q;
	logic [RECIP_W-1:0] quo_q;
	logic [STEP_W-1:0]  cnt_q;
	logic               busy_q;

	logic [DIV_W:0]     rem_sh;
	logic               qbit;
	logic [DIV_W:0]     rem_sub;

	// The dividend is a one followed by RECIP_SHIFT zeros.
	always_comb begin
		rem_sh  = {rem_q, (cnt_q == '0)};
		qbit    = (rem_sh >= {1'b0, d_q});
		rem_sub = rem_sh - {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= DIV_W'(1);
			quo_q  <= RECIP_W'(1) << RECIP_SHIFT;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			rem_q  <= '0;
			d_q    <= d;
			quo_q  <= '0;
		end else if (busy_q) begin
			rem_q  <= qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
			quo_q  <= {quo_q[RECIP_W-2:0], qbit};
			cnt_q  <= cnt_q + STEP_W'(1);
			if (cnt_q == STEP_W'(RECIP_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign stat.busy  = busy_q;
	assign stat.recip = quo_q;

endmodule

>>> sim/grid_mesh_generator_tb.sv
// Self-checking testbench for grid_mesh_generator: a directed table of vertex and cell
// requests, then randomized phases under random grid setups, checked against a predictor.
// Depends on gmg_pkg and the grid_mesh_generator RTL; reads no files.
`timescale 1ns / 1ps

module grid_mesh_generator_tb;

	import gmg_pkg::*;

	// Test plan
	// ---------
	// Every accepted request is turned into its expected result at the moment it is
	// driven, and that result waits in mesh_due until the block hands back a result.
	// Results come back in order, so each one is compared, field by field, with the
	// oldest entry. The directed table runs first, under the reset grid and then under
	// a few hand-picked setups: the grid extremes, the clamps on cols and rows, the
	// range errors of both modes and writes to indexes past the register file.
	// After that, random phases each load a fresh grid setup and stream random requests,
	// most of them inside the grid so the arithmetic gets exercised.
	//
	// Registers are only written while nothing is in flight. Both sides idle at random;
	// one phase stalls the output for a long stretch while requests keep coming, and
	// another makes the sender wait until every due result has come back.

	localparam int N_DIR        = 38;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_ITEMS  = 235;
	localparam int IDLE_LIMIT   = 4000;  // cycles with no handshake before giving up
	localparam int DRAIN_CYCLES = 20;    // five-stage pipeline, plus margin
	localparam int LONG_HOLD    = 400;

	// Indexes past the end of the register file; writes to these must be ignored.
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;

	typedef struct packed {
		logic [POS_W-1:0] pos_x;
		logic [POS_W-1:0] pos_y;
		logic [TEX_W-1:0] tex_u;
		logic [TEX_W-1:0] tex_v;
		logic [IDX_W-1:0] idx_a;
		logic [IDX_W-1:0] idx_b;
		logic [IDX_W-1:0] idx_c;
		logic [IDX_W-1:0] idx_d;
		logic [IDX_W-1:0] idx_e;
		logic [IDX_W-1:0] idx_f;
		logic             range_error;
	} mesh_res_t;

	localparam mesh_res_t RANGE_ERR = '{range_error: 1'b1, default: '0};

	typedef enum logic {STEP_REQ, STEP_CFG} step_kind_t;

	typedef struct {
		step_kind_t            kind;
		logic [CFG_ADDR_W-1:0] addr;
		logic [CFG_W-1:0]      wdata;
		logic                  mode;
		logic [COORD_W-1:0]    row;
		logic [COORD_W-1:0]    col;
		bit                    typed;   // want holds a hand-written result
		mesh_res_t             want;
	} dir_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  s_tuser = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// Shadow copy of the register file, as the block should hold it.
	logic [DIM_W-1:0] cols_reg;
	logic [DIM_W-1:0] rows_reg;
	logic [15:0]      half_w_reg;
	logic [15:0]      half_h_reg;
	logic [15:0]      tile_x_reg;
	logic [15:0]      tile_y_reg;

	mesh_res_t mesh_due [$];   // results owed by the block, oldest first
	mesh_res_t due_next;       // result of the request currently offered
	mesh_res_t seen;
	dir_step_t dir_tab [N_DIR];
	int        errors = 0;
	int        quiet_cycles = 0;
	int        hold_req = 0;   // set by the sender to ask for one long output stall
	int        stall_left = 0;
	int        steady_left = 0;

	grid_mesh_generator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Effective grid size: the block treats anything below two as two and anything
	// above the grid limit as the limit.
	function automatic int eff_dim(input logic [DIM_W-1:0] v);
		if (v < 2) begin
			return 2;
		end else if (v > GRID_MAX) begin
			return GRID_MAX;
		end
		return int'(v);
	endfunction

	// Position in signed Q4.12: half * (2*frac - 1), floored toward minus infinity.
	// The arithmetic shift of a negative product gives exactly that floor.
	function automatic logic [POS_W-1:0] place(input logic [15:0] half, input longint frac);
		longint prod;
		prod = longint'(half) * (2 * frac - 65536);
		return POS_W'(prod >>> 16);
	endfunction

	function automatic mesh_res_t tessellate(input logic md, input logic [COORD_W-1:0] rw,
			input logic [COORD_W-1:0] cl);
		mesh_res_t res;
		int        nc;
		int        nr;
		longint    fu;
		longint    fv;
		int        lo;
		int        hi;
		res = '0;
		nc = eff_dim(cols_reg);
		nr = eff_dim(rows_reg);
		if (md == MODE_VERTEX) begin
			if (rw >= nr || cl >= nc) begin
				res.range_error = 1'b1;
			end else begin
				// Grid fractions in Q1.16, 0 at the first vertex and 65536 at the last.
				fu = (longint'(cl) << 16) / longint'(nc - 1);
				fv = (longint'(rw) << 16) / longint'(nr - 1);
				res.pos_x = place(half_w_reg, fu);
				res.pos_y = place(half_h_reg, fv);
				res.tex_u = TEX_W'((fu * longint'(tile_x_reg)) >> 8);
				res.tex_v = TEX_W'((fv * longint'(tile_y_reg)) >> 8);
			end
		end else begin
			if (rw + 1 >= nr || cl + 1 >= nc) begin
				res.range_error = 1'b1;
			end else begin
				lo = int'(cl) + nc * int'(rw);
				hi = lo + nc;
				res.idx_a = IDX_W'(lo);
				res.idx_b = IDX_W'(lo + 1);
				res.idx_c = IDX_W'(hi);
				res.idx_d = IDX_W'(lo + 1);
				res.idx_e = IDX_W'(hi + 1);
				res.idx_f = IDX_W'(hi);
			end
		end
		return res;
	endfunction

	function automatic mesh_res_t vert_res(input int px, input int py, input int tu,
			input int tv);
		mesh_res_t res;
		res = '0;
		res.pos_x = POS_W'(px);
		res.pos_y = POS_W'(py);
		res.tex_u = TEX_W'(tu);
		res.tex_v = TEX_W'(tv);
		return res;
	endfunction

	function automatic mesh_res_t cell_res(input int a, input int b, input int c, input int d,
			input int e, input int f);
		mesh_res_t res;
		res = '0;
		res.idx_a = IDX_W'(a);
		res.idx_b = IDX_W'(b);
		res.idx_c = IDX_W'(c);
		res.idx_d = IDX_W'(d);
		res.idx_e = IDX_W'(e);
		res.idx_f = IDX_W'(f);
		return res;
	endfunction

	function automatic void compare_result(input mesh_res_t want, input mesh_res_t got);
		if (got.pos_x !== want.pos_x) begin
			$error("pos_x: expected %0d, got %0d", $signed(want.pos_x), $signed(got.pos_x));
			errors++;
		end
		if (got.pos_y !== want.pos_y) begin
			$error("pos_y: expected %0d, got %0d", $signed(want.pos_y), $signed(got.pos_y));
			errors++;
		end
		if (got.tex_u !== want.tex_u) begin
			$error("tex_u: expected %0d, got %0d", want.tex_u, got.tex_u);
			errors++;
		end
		if (got.tex_v !== want.tex_v) begin
			$error("tex_v: expected %0d, got %0d", want.tex_v, got.tex_v);
			errors++;
		end
		if (got.idx_a !== want.idx_a) begin
			$error("idx_a: expected %0d, got %0d", want.idx_a, got.idx_a);
			errors++;
		end
		if (got.idx_b !== want.idx_b) begin
			$error("idx_b: expected %0d, got %0d", want.idx_b, got.idx_b);
			errors++;
		end
		if (got.idx_c !== want.idx_c) begin
			$error("idx_c: expected %0d, got %0d", want.idx_c, got.idx_c);
			errors++;
		end
		if (got.idx_d !== want.idx_d) begin
			$error("idx_d: expected %0d, got %0d", want.idx_d, got.idx_d);
			errors++;
		end
		if (got.idx_e !== want.idx_e) begin
			$error("idx_e: expected %0d, got %0d", want.idx_e, got.idx_e);
			errors++;
		end
		if (got.idx_f !== want.idx_f) begin
			$error("idx_f: expected %0d, got %0d", want.idx_f, got.idx_f);
			errors++;
		end
		if (got.range_error !== want.range_error) begin
			$error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
			errors++;
		end
	endfunction

	// Mostly no gap or a short one, now and then a long one.
	function automatic int idle_len();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55) begin
			return 0;
		end else if (sel < 85) begin
			return $urandom_range(1, 3);
		end else if (sel < 97) begin
			return $urandom_range(4, 12);
		end
		return $urandom_range(20, 60);
	endfunction

	// Grid size register values: mostly legal sizes, but also the clamped ones below
	// two and above the limit, and raw 16-bit words whose upper bits are dropped.
	function automatic logic [CFG_W-1:0] pick_dim();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 3) begin
			return CFG_W'($urandom_range(2, 9));
		end else if (sel < 5) begin
			return CFG_W'($urandom_range(10, 256));
		end else if (sel < 7) begin
			return CFG_W'(256);
		end else if (sel == 7) begin
			return CFG_W'($urandom_range(0, 1));
		end else if (sel == 8) begin
			return CFG_W'($urandom_range(257, 511));
		end
		return CFG_W'($urandom_range(0, 65535));
	endfunction

	function automatic logic [CFG_W-1:0] pick_word();
		int sel;
		sel = $urandom_range(0, 5);
		if (sel == 0) begin
			return '0;
		end else if (sel == 1) begin
			return '1;
		end
		return CFG_W'($urandom_range(0, 65535));
	endfunction

	// Offer one request and hold it until the block takes it. The result it should
	// produce is published at the same falling edge, so the monitor can queue it.
	task automatic send_req(input logic md, input logic [COORD_W-1:0] rw,
			input logic [COORD_W-1:0] cl, input mesh_res_t due);
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= md;
		s_tdata  <= {cl, rw};
		due_next = due;
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	task automatic sender_idle(input int cycles);
		@(negedge clk);
		s_tvalid <= 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		while (mesh_due.size() != 0) @(posedge clk);
	endtask

	// A cols or rows write keeps s_tready low while the reciprocal is recomputed, so
	// requests that follow simply wait on the handshake.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		case (addr)
			REG_COLS:   cols_reg   = data[DIM_W-1:0];
			REG_ROWS:   rows_reg   = data[DIM_W-1:0];
			REG_HALF_W: half_w_reg = data;
			REG_HALF_H: half_h_reg = data;
			REG_TILE_X: tile_x_reg = data;
			REG_TILE_Y: tile_y_reg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_random_setup(input bit full_grid);
		if ($urandom_range(0, 2) == 0) begin
			write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, pick_word());
		end
		write_reg(REG_COLS, full_grid ? CFG_W'(GRID_MAX) : pick_dim());
		write_reg(REG_ROWS, full_grid ? CFG_W'(GRID_MAX) : pick_dim());
		write_reg(REG_HALF_W, pick_word());
		write_reg(REG_HALF_H, pick_word());
		write_reg(REG_TILE_X, pick_word());
		write_reg(REG_TILE_Y, pick_word());
	endtask

	// Most requests land inside the grid for their mode, some on its corners;
	// the rest are arbitrary coordinates, which often hit the range check.
	task automatic pick_request(input int nc, input int nr, output logic md,
			output logic [COORD_W-1:0] rw, output logic [COORD_W-1:0] cl);
		int sel;
		int rmax;
		int cmax;
		sel  = $urandom_range(0, 99);
		md   = 1'($urandom_range(0, 1));
		rmax = (md == MODE_CELL) ? nr - 2 : nr - 1;
		cmax = (md == MODE_CELL) ? nc - 2 : nc - 1;
		if (sel < 12) begin
			rw = $urandom_range(0, 1) ? COORD_W'(rmax) : '0;
			cl = $urandom_range(0, 1) ? COORD_W'(cmax) : '0;
		end else if (sel < 85) begin
			rw = COORD_W'($urandom_range(0, rmax));
			cl = COORD_W'($urandom_range(0, cmax));
		end else begin
			rw = COORD_W'($urandom_range(0, 255));
			cl = COORD_W'($urandom_range(0, 255));
		end
	endtask

	// Output side: idles at random, runs stretches with no stall at all, and honors
	// one requested long hold-off, counted here.
	always @(negedge clk) begin
		if (hold_req > 0) begin
			stall_left = hold_req;
			hold_req   = 0;
		end
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (steady_left > 0) begin
				steady_left--;
			end else if ($urandom_range(0, 99) < 5) begin
				steady_left = $urandom_range(30, 120);
			end else begin
				stall_left = idle_len();
			end
		end
	end

	// Monitor: take the result first, then queue the request accepted at this edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen.pos_x       = m_tdata[16:0];
				seen.pos_y       = m_tdata[33:17];
				seen.tex_u       = m_tdata[57:34];
				seen.tex_v       = m_tdata[81:58];
				seen.idx_a       = m_tdata[97:82];
				seen.idx_b       = m_tdata[113:98];
				seen.idx_c       = m_tdata[129:114];
				seen.idx_d       = m_tdata[145:130];
				seen.idx_e       = m_tdata[161:146];
				seen.idx_f       = m_tdata[177:162];
				seen.range_error = m_tuser;
				if (mesh_due.size() == 0) begin
					$error("result delivered while no request was outstanding");
					errors++;
				end else begin
					compare_result(mesh_due.pop_front(), seen);
				end
			end
			if (s_tvalid && s_tready) begin
				mesh_due.push_back(due_next);
			end
		end
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$error("no handshake for %0d cycles, %0d results still due", IDLE_LIMIT,
				mesh_due.size());
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		logic               md;
		logic [COORD_W-1:0] rw;
		logic [COORD_W-1:0] cl;
		int                 nc;
		int                 nr;
		int                 gap;
		bit                 in_cfg;

		// Register values after reset: a two by two grid, unit extents, unit tiling.
		cols_reg   = 9'd2;
		rows_reg   = 9'd2;
		half_w_reg = 16'd2048;
		half_h_reg = 16'd2048;
		tile_x_reg = 16'd256;
		tile_y_reg = 16'd256;
		due_next   = '0;

		dir_tab = '{
			// Reset grid: three of the four corners, the single cell, and range errors.
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd0, 8'd0, 1'b1,
				vert_res(-2048, -2048, 0, 0)},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd0, 8'd1, 1'b1,
				vert_res(2048, -2048, 65536, 0)},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd1, 8'd1, 1'b1,
				vert_res(2048, 2048, 65536, 65536)},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd0, 8'd0, 1'b1, cell_res(0, 1, 2, 1, 3, 2)},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd0, 8'd1, 1'b1, RANGE_ERR},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd1, 8'd0, 1'b1, RANGE_ERR},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd2, 8'd0, 1'b1, RANGE_ERR},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd255, 8'd255, 1'b1, RANGE_ERR},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd255, 8'd255, 1'b1, RANGE_ERR},
			// Largest grid (rows above the limit clamps), widest extent, full tiling.
			'{STEP_CFG, REG_COLS, 16'd256, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_ROWS, 16'd511, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_HALF_W, 16'hFFFF, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_HALF_H, 16'h0000, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_TILE_X, 16'hFFFF, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_TILE_Y, 16'h0000, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd255, 8'd255, 1'b1,
				vert_res(65535, 0, 16776960, 0)},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd0, 8'd0, 1'b1,
				vert_res(-65535, 0, 0, 0)},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd254, 8'd254, 1'b1,
				cell_res(65278, 65279, 65534, 65279, 65535, 65534)},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd255, 8'd0, 1'b1, RANGE_ERR},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd128, 8'd127, 1'b0, '0},
			// Writes past the register file, then sizes that clamp up to two.
			'{STEP_CFG, REG_SPARE_A, 16'hFFFF, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_SPARE_B, 16'h1234, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_COLS, 16'd1, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_ROWS, 16'h0200, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_HALF_W, 16'h0000, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_HALF_H, 16'hFFFF, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_TILE_X, 16'h0000, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_TILE_Y, 16'hFFFF, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd1, 8'd1, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd0, 8'd0, 1'b1, cell_res(0, 1, 2, 1, 3, 2)},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd0, 8'd2, 1'b1, RANGE_ERR},
			// Odd grid sizes, where the fraction floors.
			'{STEP_CFG, REG_COLS, 16'd3, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_CFG, REG_ROWS, 16'd255, MODE_VERTEX, '0, '0, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd0, 8'd1, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd254, 8'd2, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd253, 8'd1, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_VERTEX, 8'd1, 8'd2, 1'b0, '0},
			'{STEP_REQ, REG_COLS, '0, MODE_CELL, 8'd0, 8'd2, 1'b1, RANGE_ERR}
		};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part. A run of register writes first waits until the pipeline
		// has returned every result it owes.
		in_cfg = 1'b0;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == STEP_CFG) begin
				if (!in_cfg) begin
					sender_idle(1);
					drain_results();
					in_cfg = 1'b1;
				end
				write_reg(dir_tab[i].addr, dir_tab[i].wdata);
			end else begin
				in_cfg = 1'b0;
				send_req(dir_tab[i].mode, dir_tab[i].row, dir_tab[i].col,
					dir_tab[i].typed ? dir_tab[i].want
					: tessellate(dir_tab[i].mode, dir_tab[i].row, dir_tab[i].col));
				gap = idle_len();
				if (gap > 0) begin
					sender_idle(gap);
				end
			end
		end

		// Random phases. The first one uses the full 256 by 256 grid so that every
		// coordinate bit is reached by in-range requests.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			sender_idle(1);
			drain_results();
			load_random_setup(ph == 0);
			nc = eff_dim(cols_reg);
			nr = eff_dim(rows_reg);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick_request(nc, nr, md, rw, cl);
				send_req(md, rw, cl, tessellate(md, rw, cl));
				if (ph == 2 && k == 40) begin
					// Block the output for a long while and keep offering back to
					// back, so the pipeline fills and s_tready has to drop.
					hold_req = LONG_HOLD;
				end
				if (ph == 4 && k == 120) begin
					sender_idle(1);
					drain_results();
				end
				if ((ph == 2 && k >= 40 && k < 80) || (k % 100 >= 60 && k % 100 < 80)) begin
					gap = 0;
				end else begin
					gap = idle_len();
				end
				if (gap > 0) begin
					sender_idle(gap);
				end
			end
		end

		sender_idle(1);
		drain_results();
		// Give a stray extra result time to show up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> filelist.f
hdl/gmg_pkg.sv
hdl/gmg_recip.sv
hdl/grid_mesh_generator.sv
sim/grid_mesh_generator_tb.sv
